// File: design/ewma_mean_std_tracker_top_macros.svh
// assertion macros for the tracker checker
`ifndef EWMA_MEAN_STD_TRACKER_TOP_MACROS_SVH
`define EWMA_MEAN_STD_TRACKER_TOP_MACROS_SVH
// implication checked every clock outside reset
`define EMS_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
// next-cycle implication
`define EMS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

// File: design/ems_pkg.sv
`default_nettype none
package ems_pkg;
  localparam int unsigned ALPHA_ONE = 65536;

  typedef struct packed {
    logic signed [31:0] sample;
    logic [1:0]         mode;
    logic [16:0]        alpha_value;
    logic               mean_reset;
    logic               mean_reset_present;
    logic signed [31:0] mean_reset_value;
    logic               dev_reset;
    logic               dev_reset_present;
    logic [30:0]        dev_reset_value;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] mean_out;
    logic [31:0]        deviation_out;
    logic [9:0]         bin_index;
    logic               last_in_frame;
  } out_item_t;

  typedef enum logic [2:0] {
    CFG_ALPHA_UP     = 3'd0,
    CFG_ALPHA_DOWN   = 3'd1,
    CFG_MEAN_PAD     = 3'd2,
    CFG_DEV_PAD      = 3'd3,
    CFG_FRAME_LENGTH = 3'd4
  } cfg_index_t;

  typedef enum logic [1:0] {
    MODE_REGS   = 2'd0,
    MODE_ITEM   = 2'd1,
    MODE_HELD   = 2'd2,
    MODE_REGS_B = 2'd3
  } mode_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_READ, ST_LOAD, ST_DELTA, ST_MULQ, ST_MEAN, ST_MULA,
    ST_SUM, ST_SCLO, ST_SCHI, ST_SCADD, ST_ROOT, ST_SQRT, ST_WRITE, ST_OUT
  } state_t;

  typedef struct packed {
    logic read_mem;
    logic load;
    logic delta;
    logic mulq;
    logic mean_upd;
    logic mula;
    logic sum;
    logic sclo;
    logic schi;
    logic scadd;
    logic sqrt_start;
    logic write_mem;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic sqrt_done;
  } status_t;
endpackage
`default_nettype wire

// File: design/ewma_mean_std_tracker_top.sv
// one item at a time: a new item is accepted only after the previous result is loaded,
// with the pace set by the 32-step square root unit
// and the chained multiply and scale steps of the datapath
// a stalled result holds the next item in its write step until it is taken
// reset: synchronous rst; stores are not cleared, a full reset of each bin
// is done on the first frame after reset or a frame length write
`default_nettype none
module ewma_mean_std_tracker_top #(
  parameter int unsigned MAX_BINS = 1024
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire ems_pkg::in_item_t  in_data,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output ems_pkg::out_item_t      out_data,
  input  wire logic               cfg_we,
  input  wire logic [2:0]         cfg_index,
  input  wire logic [31:0]        cfg_data
);
  import ems_pkg::*;

  cmd_t    cmd;
  status_t status;

  // sequencer
  ems_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
    .out_valid(out_valid), .out_stall(out_stall), .cmd(cmd), .status(status)
  );

  // arithmetic and bin stores
  ems_datapath #(.MAX_BINS(MAX_BINS)) u_dp (
    .clk(clk), .rst(rst), .in_data(in_data), .cfg_we(cfg_we),
    .cfg_index(cfg_index), .cfg_data(cfg_data), .cmd(cmd), .status(status),
    .out_data(out_data)
  );
endmodule
`default_nettype wire

// File: design/ems_ctrl.sv
`default_nettype none
module ems_ctrl (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  output logic               in_stall,
  output logic               out_valid,
  input  wire logic          out_stall,
  output ems_pkg::cmd_t      cmd,
  input  wire ems_pkg::status_t status
);
  import ems_pkg::*;

  state_t state, state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else state <= state_next;
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:  if (in_valid) state_next = ST_READ;
      ST_READ:  state_next = ST_LOAD;
      ST_LOAD:  state_next = ST_DELTA;
      ST_DELTA: state_next = ST_MULQ;
      ST_MULQ:  state_next = ST_MEAN;
      ST_MEAN:  state_next = ST_MULA;
      ST_MULA:  state_next = ST_SUM;
      ST_SUM:   state_next = ST_SCLO;
      ST_SCLO:  state_next = ST_SCHI;
      ST_SCHI:  state_next = ST_SCADD;
      ST_SCADD: state_next = ST_ROOT;
      ST_ROOT:  state_next = ST_SQRT;
      ST_SQRT:  if (status.sqrt_done) state_next = ST_WRITE;
      ST_WRITE: if (!out_valid || !out_stall) state_next = ST_OUT;
      ST_OUT:   state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  // output valid register, freed when the item is taken
  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (cmd.out_load) out_valid <= 1'b1;
    else if (!out_stall) out_valid <= 1'b0;
  end

  // commands
  always_comb begin
    cmd = '0;
    in_stall = (state != ST_IDLE);
    unique case (state)
      ST_IDLE:  cmd.read_mem = in_valid;
      ST_READ:  ;
      ST_LOAD:  cmd.load = 1'b1;
      ST_DELTA: cmd.delta = 1'b1;
      ST_MULQ:  cmd.mulq = 1'b1;
      ST_MEAN:  cmd.mean_upd = 1'b1;
      ST_MULA:  cmd.mula = 1'b1;
      ST_SUM:   cmd.sum = 1'b1;
      ST_SCLO:  cmd.sclo = 1'b1;
      ST_SCHI:  cmd.schi = 1'b1;
      ST_SCADD: begin
        cmd.scadd = 1'b1;
      end
      // root starts once the variance is in place, scaled unless the deviation was reset
      ST_ROOT:  cmd.sqrt_start = 1'b1;
      ST_SQRT:  ;
      ST_WRITE: begin
        cmd.write_mem = !out_valid || !out_stall;
        cmd.out_load = !out_valid || !out_stall;
      end
      ST_OUT:   ;
      default:  ;
    endcase
  end
endmodule
`default_nettype wire

// File: design/ems_sqrt.sv
`default_nettype none
module ems_sqrt (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  input  wire logic [63:0] value,
  output logic             done,
  output logic [31:0]      root
);
  logic [63:0] rem;
  logic [63:0] acc;
  logic [5:0]  step;
  logic        busy;
  logic [63:0] trial;
  logic [63:0] bitv;

  // one result bit per cycle, restoring
  always_comb begin
    bitv  = 64'd1 << {step[4:0], 1'b0};
    trial = acc + bitv;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        step <= 6'd31;
      end else if (busy) begin
        if (step == 6'd0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
        step <= step - 6'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= value;
      acc <= '0;
    end else if (busy) begin
      if (rem >= trial) begin
        rem <= rem - trial;
        acc <= (acc >> 1) + bitv;
      end else begin
        acc <= acc >> 1;
      end
    end
  end

  assign root = acc[31:0];
endmodule
`default_nettype wire

// File: design/ems_datapath.sv
`default_nettype none
module ems_datapath #(
  parameter int unsigned MAX_BINS = 1024
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire ems_pkg::in_item_t in_data,
  input  wire logic              cfg_we,
  input  wire logic [2:0]        cfg_index,
  input  wire logic [31:0]       cfg_data,
  input  wire ems_pkg::cmd_t     cmd,
  output ems_pkg::status_t       status,
  output ems_pkg::out_item_t     out_data
);
  import ems_pkg::*;
  localparam int AW = (MAX_BINS > 1) ? $clog2(MAX_BINS) : 1;

  logic [16:0] rise_alpha, fall_alpha;
  logic signed [31:0] mean_pad;
  logic [30:0] deviation_pad;
  logic [10:0] frame_length;
  logic [AW-1:0] bin_position;
  logic full_reset_pending;
  logic [16:0] held_alpha;

  logic signed [31:0] mean_mem [MAX_BINS];
  logic [63:0] var_mem [MAX_BINS];
  logic signed [31:0] mean_rd;
  logic [63:0] var_rd;

  in_item_t it;
  logic [AW-1:0] pos;
  logic last;
  logic rm, rd;
  logic signed [31:0] mean;
  logic [63:0] var_v;
  logic [16:0] alpha;
  logic neg;
  logic [32:0] mag;
  logic [49:0] q;
  logic [63:0] add;
  logic [63:0] s;
  logic [48:0] p_lo;
  logic [48:0] p_hi;
  logic [61:0] dv_sq;
  logic [16:0] cmp;
  logic [31:0] root;
  logic        sqrt_done;

  // effective frame length clamp
  logic [16:0] len_eff;
  always_comb begin
    if (frame_length == 11'd0) len_eff = 17'd1;
    else if ({6'd0, frame_length} > 17'(MAX_BINS)) len_eff = 17'(MAX_BINS);
    else len_eff = {6'd0, frame_length};
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      rise_alpha <= 17'd32768;
      fall_alpha <= 17'd32768;
      mean_pad <= '0;
      deviation_pad <= '0;
      frame_length <= 11'd1024;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_ALPHA_UP:     rise_alpha <= cfg_data[16:0];
        CFG_ALPHA_DOWN:   fall_alpha <= cfg_data[16:0];
        CFG_MEAN_PAD:     mean_pad <= cfg_data;
        CFG_DEV_PAD:      deviation_pad <= cfg_data[30:0];
        CFG_FRAME_LENGTH: frame_length <= cfg_data[10:0];
        default: ;
      endcase
    end
  end

  // memories
  always_ff @(posedge clk) begin
    if (cmd.read_mem) begin
      mean_rd <= mean_mem[pos];
      var_rd <= var_mem[pos];
    end
    if (cmd.write_mem) begin
      mean_mem[pos] <= mean;
      var_mem[pos] <= var_v;
    end
  end

  always_comb pos = ({{(17-AW){1'b0}}, bin_position} >= len_eff) ? '0 : bin_position;
  always_comb last = ({{(17-AW){1'b0}}, pos} + 17'd1 >= len_eff);

  // frame position and pending full reset
  always_ff @(posedge clk) begin
    if (rst) begin
      bin_position <= '0;
      full_reset_pending <= 1'b1;
      held_alpha <= '0;
    end else begin
      if (cfg_we && cfg_index == CFG_FRAME_LENGTH) begin
        bin_position <= '0;
        full_reset_pending <= 1'b1;
      end else if (cmd.write_mem) begin
        if (last) begin
          bin_position <= '0;
          full_reset_pending <= 1'b0;
        end else begin
          bin_position <= pos + AW'(1);
        end
      end
      if (cmd.read_mem && in_data.mode == MODE_ITEM)
        held_alpha <= (in_data.alpha_value > 17'(ALPHA_ONE)) ? 17'(ALPHA_ONE)
                                                             : in_data.alpha_value;
    end
  end

  always_comb cmp = 17'(ALPHA_ONE) - alpha;

  // arithmetic sequence
  always_ff @(posedge clk) begin
    if (cmd.read_mem) begin
      it <= in_data;
      rm <= in_data.mean_reset | full_reset_pending;
      rd <= in_data.dev_reset | full_reset_pending;
    end
    if (cmd.load) begin
      mean <= rm ? (it.mean_reset_present ? it.mean_reset_value : mean_pad) : mean_rd;
      var_v <= var_rd;
    end
    if (cmd.delta) begin
      if (rd) var_v <= {2'd0, dv_sq};
      unique case (mode_t'(it.mode))
        MODE_ITEM: alpha <= (it.alpha_value > 17'(ALPHA_ONE)) ? 17'(ALPHA_ONE)
                                                              : it.alpha_value;
        MODE_HELD: alpha <= held_alpha;
        MODE_REGS, MODE_REGS_B: begin
          if (it.sample > mean)
            alpha <= (rise_alpha > 17'(ALPHA_ONE)) ? 17'(ALPHA_ONE) : rise_alpha;
          else
            alpha <= (fall_alpha > 17'(ALPHA_ONE)) ? 17'(ALPHA_ONE) : fall_alpha;
        end
        default: alpha <= fall_alpha;
      endcase
      neg <= (it.sample < mean);
      mag <= (it.sample < mean) ? 33'({mean[31], mean} - {it.sample[31], it.sample})
                                : 33'({it.sample[31], it.sample} - {mean[31], mean});
    end
    if (cmd.mulq) q <= 50'(({33'd0, alpha} * {17'd0, mag} + 50'd32768) >> 16);
    if (cmd.mean_upd && !(rm && rd) && !rm)
      mean <= neg ? mean - q[31:0] : mean + q[31:0];
    if (cmd.mula) add <= 64'(q[33:0] * {1'b0, mag});
    if (cmd.sum) s <= (var_v + add < add) ? '1 : var_v + add;
    if (cmd.sclo) p_lo <= 49'((cmp * s[31:0] + 49'd32768) >> 16);
    if (cmd.schi) p_hi <= 49'(cmp * s[63:32]);
    if (cmd.scadd && !rd && !rm) var_v <= 64'({p_hi, 16'd0}) + {15'd0, p_lo};
    if (cmd.scadd && !rd && rm) var_v <= 64'({p_hi, 16'd0}) + {15'd0, p_lo};
    if (cmd.out_load) begin
      out_data.mean_out <= mean;
      out_data.deviation_out <= root;
      out_data.bin_index <= 10'(pos);
      out_data.last_in_frame <= last;
    end
  end

  // starting deviation squared
  logic [30:0] dv;
  always_comb dv = it.dev_reset_present ? it.dev_reset_value : deviation_pad;
  always_comb dv_sq = dv * dv;

  ems_sqrt u_sqrt (
    .clk(clk), .rst(rst), .start(cmd.sqrt_start), .value(var_v),
    .done(sqrt_done), .root(root)
  );
  always_comb status.sqrt_done = sqrt_done;
endmodule
`default_nettype wire

// File: design/ems_checker.sv
`default_nettype none
`include "ewma_mean_std_tracker_top_macros.svh"
module ems_checker (
  input wire logic clk,
  input wire logic rst,
  input wire logic in_valid,
  input wire logic in_stall,
  input wire logic out_valid,
  input wire logic out_stall
);
  // one item at a time: once an item is accepted, the input is stalled
  `EMS_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall)
  // a stalled result stays offered
  `EMS_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid)
  // the block does not accept while a result is first being offered
  `EMS_ASSERT_IMPL(a_rose_out, $rose(out_valid), in_stall)
endmodule
bind ewma_mean_std_tracker_top ems_checker u_chk (
  .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
  .out_valid(out_valid), .out_stall(out_stall)
);
`default_nettype wire
